// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checksum checker RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FMCC_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("fmcc assertion failed");

// Next-cycle implication, disabled during reset.
`define FMCC_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("fmcc assertion failed");

`endif

// ===== rtl/core/fmcc_pkg.sv =====
// Types and constants of the framed message checksum checker.
// No dependencies.
package fmcc_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_FMT = 2'd1,
    ST_NOT_NUM = 2'd2,
    ST_MISMATCH = 2'd3
  } status_e;

  localparam logic [31:0] MARK_HEAD = 32'h3B43_4B53;  // ";CKS"
  localparam logic [7:0]  MARK_TAIL = 8'h3A;          // ':'
  localparam logic [7:0]  CH_SEMI   = 8'h3B;
  localparam logic [7:0]  CH_CLOSE  = 8'h3E;
  localparam logic [7:0]  CH_ZERO   = 8'h30;
  localparam logic [7:0]  CH_NINE   = 8'h39;
  // Subtracting the marker bytes (342) mod 256 is adding 170.
  localparam logic [7:0]  MARK_SUM_ADJ = 8'd170;
  localparam logic [8:0]  CKS_SAT   = 9'd256;
  localparam int unsigned MARK_LEN  = 5;

  localparam int unsigned FLAG_DIGIT  = 0;
  localparam int unsigned FLAG_BAD    = 1;
  localparam int unsigned FLAG_CLOSED = 2;

  typedef struct packed {
    logic       marker_found;
    logic [7:0] snap_sum;
  } frame_t;

  typedef struct packed {
    logic [8:0] value;
    logic [2:0] flags;
  } field_t;

endpackage

// ===== rtl/core/fmcc_in_if.sv =====
// Input byte channel of the checksum checker.
// No dependencies.
interface fmcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/fmcc_out_if.sv =====
// Result channel of the checksum checker.
// No dependencies.
interface fmcc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] computed_sum;
  logic [8:0] received_checksum;
  logic [9:0] payload_length;

  modport source (output valid, output status, output computed_sum,
                  output received_checksum, output payload_length, input ready);
  modport sink (input valid, input status, input computed_sum,
                input received_checksum, input payload_length, output ready);
endinterface

// ===== rtl/core/framed_message_checksum_checker_top.sv =====
// Framed message checksum checker: one byte per cycle, one result per message.
// Result: the last byte is registered on input, then its verdict loads the result register.
// Throughput: one byte per cycle; a last byte stalls only while a prior result is not taken.
// Reset: asynchronous active low; clears all frame state and the result valid.
// Depends on fmcc_pkg, fmcc_in_if, fmcc_out_if, fmcc_frame_track, fmcc_digit_parse, fmcc_result.
module framed_message_checksum_checker_top import fmcc_pkg::*; #(
  parameter int unsigned LENGTH_COUNT_MAX = 1023
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fmcc_in_if.sink    in_i,
  fmcc_out_if.source out_o
);

  localparam int unsigned SNAP_W = $clog2(LENGTH_COUNT_MAX + 1);

  logic              in_valid_q;
  logic [7:0]        byte_q;
  logic              last_q;
  logic              advance;
  logic              is_marker;
  logic              marker_q;
  frame_t            frame_d;
  logic [SNAP_W-1:0] snap_len_d;
  field_t            field_d;

  assign advance    = in_valid_q && (!last_q || !out_o.valid || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q <= in_i.data_byte;
      last_q <= in_i.last_byte;
    end
  end

  fmcc_frame_track #(
    .LENGTH_COUNT_MAX(LENGTH_COUNT_MAX),
    .SNAP_W(SNAP_W)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .last_i      (last_q),
    .byte_i      (byte_q),
    .is_marker_o (is_marker),
    .marker_q_o  (marker_q),
    .frame_d_o   (frame_d),
    .snap_len_d_o(snap_len_d)
  );

  fmcc_digit_parse u_digit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .last_i     (last_q),
    .byte_i     (byte_q),
    .marker_q_i (marker_q),
    .is_marker_i(is_marker),
    .field_d_o  (field_d)
  );

  fmcc_result #(
    .SNAP_W(SNAP_W)
  ) u_result (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (advance && last_q),
    .frame_i   (frame_d),
    .snap_len_i(snap_len_d),
    .field_i   (field_d),
    .out_o     (out_o)
  );

endmodule

// ===== rtl/core/fmcc_frame_track.sv =====
// Frame tracker: start detect, payload sum and count, marker window, snapshots.
// Depends on fmcc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fmcc_frame_track import fmcc_pkg::*; #(
  parameter int unsigned LENGTH_COUNT_MAX = 1023,
  parameter int unsigned SNAP_W = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              last_i,
  input  logic [7:0]        byte_i,
  output logic              is_marker_o,
  output logic              marker_q_o,
  output frame_t            frame_d_o,
  output logic [SNAP_W-1:0] snap_len_d_o
);

  localparam int unsigned CNT_W = $clog2(LENGTH_COUNT_MAX + 6);
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(LENGTH_COUNT_MAX + 5);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LENGTH_COUNT_MAX);
  localparam logic [CNT_W-1:0] CNT_MARK = CNT_W'(MARK_LEN);

  logic              start_q, start_d;
  logic [7:0]        sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [31:0]       recent_q, recent_d;
  frame_t            frame_q, frame_d;
  logic [SNAP_W-1:0] len_q, len_d;
  logic [CNT_W-1:0]  len_raw;

  assign is_marker_o = (recent_q == MARK_HEAD) && (byte_i == MARK_TAIL);
  assign len_raw = cnt_d - CNT_MARK;

  always_comb begin
    start_d  = start_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    frame_d  = frame_q;
    len_d    = len_q;
    recent_d = {recent_q[23:0], byte_i};
    if (start_q) begin
      sum_d = sum_q + byte_i;
      if (cnt_q < CNT_SAT) begin
        cnt_d = cnt_q + 1'b1;
      end
    end else if (byte_i == CH_SEMI) begin
      start_d = 1'b1;
    end
    if (is_marker_o) begin
      frame_d.marker_found = 1'b1;
      if (start_d && (cnt_d >= CNT_MARK)) begin
        len_d = (len_raw > CNT_MAX) ? SNAP_W'(CNT_MAX) : SNAP_W'(len_raw);
        frame_d.snap_sum = sum_d + MARK_SUM_ADJ;
      end else begin
        len_d = '0;
        frame_d.snap_sum = '0;
      end
    end
  end

  assign marker_q_o   = frame_q.marker_found;
  assign frame_d_o    = frame_d;
  assign snap_len_d_o = len_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= 1'b0;
      sum_q    <= '0;
      cnt_q    <= '0;
      recent_q <= '0;
      frame_q  <= '0;
      len_q    <= '0;
    end else if (step_i) begin
      if (last_i) begin
        start_q  <= 1'b0;
        sum_q    <= '0;
        cnt_q    <= '0;
        recent_q <= '0;
        frame_q  <= '0;
        len_q    <= '0;
      end else begin
        start_q  <= start_d;
        sum_q    <= sum_d;
        cnt_q    <= cnt_d;
        recent_q <= recent_d;
        frame_q  <= frame_d;
        len_q    <= len_d;
      end
    end
  end

  `FMCC_ASSERT_IMP(a_no_marker_no_len, clk_i, rst_ni, !frame_q.marker_found, len_q == '0)
  `FMCC_ASSERT_IMP(a_len_bound, clk_i, rst_ni, 1'b1, len_q <= SNAP_W'(CNT_MAX))

endmodule

// ===== rtl/core/fmcc_digit_parse.sv =====
// Checksum field parser: saturating decimal value and field flags.
// Depends on fmcc_pkg.
module fmcc_digit_parse import fmcc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       last_i,
  input  logic [7:0] byte_i,
  input  logic       marker_q_i,
  input  logic       is_marker_i,
  output field_t     field_d_o
);

  field_t      field_q, field_d;
  logic [11:0] mac;
  logic [3:0]  digit;

  assign digit = 4'(byte_i - CH_ZERO);
  assign mac   = {field_q.value, 3'b000} + {2'b00, field_q.value, 1'b0} + {8'd0, digit};

  always_comb begin
    field_d = field_q;
    if (marker_q_i && !field_q.flags[FLAG_CLOSED]) begin
      if (byte_i == CH_CLOSE) begin
        field_d.flags[FLAG_CLOSED] = 1'b1;
      end else if (byte_i >= CH_ZERO && byte_i <= CH_NINE) begin
        field_d.value = (mac > 12'(CKS_SAT)) ? CKS_SAT : mac[8:0];
        field_d.flags[FLAG_DIGIT] = 1'b1;
      end else begin
        field_d.flags[FLAG_BAD] = 1'b1;
      end
    end
    if (is_marker_i) begin
      field_d = '0;
    end
  end

  assign field_d_o = field_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q <= '0;
    end else if (step_i) begin
      field_q <= last_i ? '0 : field_d;
    end
  end

endmodule

// ===== rtl/core/fmcc_result.sv =====
// Status decision and result register of the checksum checker.
// Depends on fmcc_pkg, fmcc_out_if and assert_macros.svh.
`include "assert_macros.svh"
module fmcc_result import fmcc_pkg::*; #(
  parameter int unsigned SNAP_W = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  frame_t            frame_i,
  input  logic [SNAP_W-1:0] snap_len_i,
  input  field_t            field_i,
  fmcc_out_if.source        out_o
);

  logic              valid_q;
  status_e           status_q, status_d;
  logic [7:0]        sum_q, sum_d;
  logic [8:0]        recv_q, recv_d;
  logic [9:0]        len_q, len_d;
  logic [SNAP_W+9:0] len_ext;

  assign len_ext = {10'd0, snap_len_i};

  always_comb begin
    sum_d  = '0;
    recv_d = '0;
    len_d  = '0;
    if (!frame_i.marker_found || snap_len_i == '0) begin
      status_d = ST_BAD_FMT;
    end else begin
      sum_d = frame_i.snap_sum;
      len_d = len_ext[9:0];
      if (!field_i.flags[FLAG_DIGIT] || field_i.flags[FLAG_BAD]) begin
        status_d = ST_NOT_NUM;
      end else begin
        recv_d   = field_i.value;
        status_d = (field_i.value == {1'b0, frame_i.snap_sum}) ? ST_OK : ST_MISMATCH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      status_q <= status_d;
      sum_q    <= sum_d;
      recv_q   <= recv_d;
      len_q    <= len_d;
    end
  end

  assign out_o.valid             = valid_q;
  assign out_o.status            = status_q;
  assign out_o.computed_sum      = sum_q;
  assign out_o.received_checksum = recv_q;
  assign out_o.payload_length    = len_q;

  `FMCC_ASSERT_IMP(a_ok_match, clk_i, rst_ni, valid_q && status_q == ST_OK,
                   recv_q == {1'b0, sum_q})
  `FMCC_ASSERT_IMP(a_bad_zero, clk_i, rst_ni, valid_q && status_q == ST_BAD_FMT,
                   sum_q == '0 && recv_q == '0 && len_q == '0)
  `FMCC_ASSERT_IMP(a_notnum_zero, clk_i, rst_ni, valid_q && status_q == ST_NOT_NUM,
                   recv_q == '0 && len_q != '0)
  `FMCC_ASSERT_NXT(a_load_valid, clk_i, rst_ni, load_i, valid_q)

endmodule

// ===== bench/framed_message_checksum_checker_top_tb.sv =====
// Testbench for framed_message_checksum_checker_top: drives framed messages byte by byte
// and checks each reported frame verdict against an in-bench frame tracker.
// Depends on fmcc_pkg, fmcc_in_if, fmcc_out_if and the RTL under rtl/core.
module framed_message_checksum_checker_top_tb;
  import fmcc_pkg::*;

  localparam int unsigned LENGTH_COUNT_MAX = 1023;
  localparam int STALL_LIMIT = 3000;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int RANDOM_BYTES = 230;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  typedef struct {
    status_e    status;
    logic [7:0] sum;
    logic [8:0] cks;
    logic [9:0] len;
  } verdict_t;

  typedef enum {
    FS_EXACT,
    FS_WRONG,
    FS_PADDED,
    FS_RANDOM,
    FS_EMPTY,
    FS_CORRUPT
  } field_style_e;

  logic clk_i;
  logic rst_ni;

  fmcc_in_if  in_if ();
  fmcc_out_if out_if ();

  framed_message_checksum_checker_top #(
    .LENGTH_COUNT_MAX(LENGTH_COUNT_MAX)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  msg_byte_t  byte_q[$];
  verdict_t   verdict_q[$];
  logic [7:0] frame_buf[$];

  int  fault_cnt;
  int  rand_bytes;
  bit  idle_on;
  bit  hold_req;
  int  send_gap;
  int  sink_gap;
  int  hold_left;
  int  quiet_cycles;
  msg_byte_t nxt_byte;
  verdict_t  got_exp;

  // frame tracker state
  logic        start_seen;
  logic [7:0]  sum_acc;
  int unsigned after_start_cnt;
  logic [31:0] tail_window;
  logic        cks_seen;
  logic [7:0]  cks_sum;
  logic [9:0]  cks_len;
  logic [8:0]  field_val;
  logic        field_has_digit;
  logic        field_bad;
  logic        field_closed;

  task automatic clear_tracker();
    start_seen      = 1'b0;
    sum_acc         = '0;
    after_start_cnt = 0;
    tail_window     = '0;
    cks_seen        = 1'b0;
    cks_sum         = '0;
    cks_len         = '0;
    field_val       = '0;
    field_has_digit = 1'b0;
    field_bad       = 1'b0;
    field_closed    = 1'b0;
  endtask

  task automatic track_byte(input logic [7:0] b, input logic last);
    logic        is_mark;
    int unsigned acc;
    int unsigned n;
    verdict_t    v;
    is_mark = (tail_window == MARK_HEAD) && (b == MARK_TAIL);
    if (start_seen) begin
      sum_acc = sum_acc + b;
      if (after_start_cnt < LENGTH_COUNT_MAX + MARK_LEN) after_start_cnt++;
    end else if (b == CH_SEMI) begin
      start_seen = 1'b1;
    end
    if (cks_seen && !field_closed) begin
      if (b == CH_CLOSE) begin
        field_closed = 1'b1;
      end else if (b >= CH_ZERO && b <= CH_NINE) begin
        acc = field_val * 10 + (b - CH_ZERO);
        field_val = (acc > CKS_SAT) ? CKS_SAT : acc[8:0];
        field_has_digit = 1'b1;
      end else begin
        field_bad = 1'b1;
      end
    end
    if (is_mark) begin
      cks_seen = 1'b1;
      if (start_seen && after_start_cnt >= MARK_LEN) begin
        n = after_start_cnt - MARK_LEN;
        cks_len = 10'((n > LENGTH_COUNT_MAX) ? LENGTH_COUNT_MAX : n);
        cks_sum = sum_acc + MARK_SUM_ADJ;
      end else begin
        cks_len = '0;
        cks_sum = '0;
      end
      field_val       = '0;
      field_has_digit = 1'b0;
      field_bad       = 1'b0;
      field_closed    = 1'b0;
    end
    tail_window = {tail_window[23:0], b};
    if (last) begin
      v.sum = '0;
      v.cks = '0;
      v.len = '0;
      if (!cks_seen || cks_len == 0) begin
        v.status = ST_BAD_FMT;
      end else begin
        v.sum = cks_sum;
        v.len = cks_len;
        if (!field_has_digit || field_bad) begin
          v.status = ST_NOT_NUM;
        end else begin
          v.cks = field_val;
          v.status = (field_val == {1'b0, cks_sum}) ? ST_OK : ST_MISMATCH;
        end
      end
      verdict_q.push_back(v);
      clear_tracker();
    end
  endtask

  // message construction
  function automatic logic [7:0] id_char();
    return $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5A))
                                : 8'($urandom_range(8'h30, 8'h39));
  endfunction

  function automatic logic [7:0] payload_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = 8'($urandom_range(0, 255));
      1: c = 8'($urandom_range(8'h20, 8'h7E));
      2: c = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: begin
        case ($urandom_range(0, 2))
          0: c = CH_SEMI;
          1: c = CH_CLOSE;
          default: c = 8'($urandom_range(CH_ZERO, CH_NINE));
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] payload_sum();
    logic [7:0] acc;
    bit         open;
    acc  = '0;
    open = 1'b0;
    foreach (frame_buf[i]) begin
      if (open) acc = acc + frame_buf[i];
      else if (frame_buf[i] == CH_SEMI) open = 1'b1;
    end
    return acc;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
  endtask

  task automatic build_body(input int plen);
    frame_buf.delete();
    repeat ($urandom_range(0, 3)) frame_buf.push_back(id_char());
    frame_buf.push_back(CH_SEMI);
    repeat (plen) frame_buf.push_back(payload_char());
  endtask

  task automatic add_field(input field_style_e style, input bit closed);
    logic [7:0] s;
    s = payload_sum();
    add_text(";CKS:");
    case (style)
      FS_EXACT:  add_text($sformatf("%0d", s));
      FS_WRONG:  add_text($sformatf("%0d", 8'(s + 8'd1)));
      FS_PADDED: add_text($sformatf("%05d", s));
      FS_RANDOM: add_text($sformatf("%0d", $urandom_range(0, 1) ? $urandom_range(0, 300)
                                                                 : $urandom_range(0, 99999)));
      FS_EMPTY:  ;
      FS_CORRUPT: begin
        add_text($sformatf("%0d", s));
        frame_buf.push_back(8'($urandom_range(0, 255)));
        add_text($sformatf("%0d", $urandom_range(0, 9)));
      end
    endcase
    if (closed) frame_buf.push_back(CH_CLOSE);
  endtask

  task automatic ship_frame(input int keep);
    int k;
    k = (keep < 1) ? 1 : (keep > frame_buf.size()) ? frame_buf.size() : keep;
    for (int i = 0; i < k; i++) byte_q.push_back('{data: frame_buf[i], last: (i == k - 1)});
    rand_bytes += k;
    frame_buf.delete();
  endtask

  task automatic ship_text(input string s);
    frame_buf.delete();
    add_text(s);
    ship_frame(frame_buf.size());
  endtask

  task automatic random_frame();
    field_style_e style;
    int           plen;
    plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: style = FS_EXACT;
      4: style = FS_WRONG;
      5: style = FS_PADDED;
      6: style = FS_RANDOM;
      7: style = FS_EMPTY;
      default: style = FS_CORRUPT;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        build_body(plen);
        add_field(style, $urandom_range(0, 6) != 0);
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3)) frame_buf.push_back(payload_char());
        ship_frame(frame_buf.size());
      end
      6: begin
        // truncated frame
        build_body(plen);
        add_field(style, 1'b1);
        ship_frame($urandom_range(1, frame_buf.size()));
      end
      7: begin
        frame_buf.delete();
        repeat ($urandom_range(1, 10)) frame_buf.push_back(payload_char());
        ship_frame(frame_buf.size());
      end
      default: begin
        // second marker overrides the first
        build_body(plen);
        add_field(FS_RANDOM, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 4)) frame_buf.push_back(payload_char());
        add_field(style, 1'b1);
        ship_frame(frame_buf.size());
      end
    endcase
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || in_if.valid || verdict_q.size() != 0) @(negedge clk_i);
  endtask

  // clock and reset
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.data_byte <= '0;
      in_if.last_byte <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) track_byte(in_if.data_byte, in_if.last_byte);
      if (!in_if.valid || in_if.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (byte_q.size() == 0) begin
          in_if.valid <= 1'b0;
        end else begin
          nxt_byte = byte_q.pop_front();
          in_if.valid     <= 1'b1;
          in_if.data_byte <= nxt_byte.data;
          in_if.last_byte <= nxt_byte.last;
          if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 16);
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      sink_gap  = 0;
      hold_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result transaction: status %0d", out_if.status);
          fault_cnt++;
        end else begin
          got_exp = verdict_q.pop_front();
          if (out_if.status !== got_exp.status) begin
            $error("status: expected %0d, actual %0d", got_exp.status, out_if.status);
            fault_cnt++;
          end
          if (out_if.computed_sum !== got_exp.sum) begin
            $error("computed_sum: expected %0d, actual %0d", got_exp.sum, out_if.computed_sum);
            fault_cnt++;
          end
          if (out_if.received_checksum !== got_exp.cks) begin
            $error("received_checksum: expected %0d, actual %0d",
                   got_exp.cks, out_if.received_checksum);
            fault_cnt++;
          end
          if (out_if.payload_length !== got_exp.len) begin
            $error("payload_length: expected %0d, actual %0d",
                   got_exp.len, out_if.payload_length);
            fault_cnt++;
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = SINK_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) sink_gap = $urandom_range(1, 16);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** framed_message_checksum_checker_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    fault_cnt    = 0;
    rand_bytes   = 0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    quiet_cycles = 0;
    clear_tracker();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed frames
    ship_text("A;hello");
    frame_buf.delete(); add_text("A;hello"); add_field(FS_EXACT, 1'b1); ship_frame(99);
    frame_buf.delete(); add_text("B;hello"); add_field(FS_WRONG, 1'b1); ship_frame(99);
    frame_buf.delete(); add_text("7;");
    frame_buf.push_back(8'h00); frame_buf.push_back(8'hFF); frame_buf.push_back(8'hFF);
    add_field(FS_EXACT, 1'b1); ship_frame(99);
    ship_text("ID;;CKS:0>");
    ship_text("ID;CKS:0>");
    frame_buf.delete(); add_text("E;x"); add_field(FS_EMPTY, 1'b1); ship_frame(99);
    frame_buf.delete(); add_text("E;x"); add_field(FS_EMPTY, 1'b0); ship_frame(99);
    frame_buf.delete(); add_text("C;x"); add_field(FS_CORRUPT, 1'b1); ship_frame(99);
    frame_buf.delete(); add_text("T;xyz"); add_field(FS_EXACT, 1'b1); add_text("junk9;");
    ship_frame(99);
    frame_buf.delete(); add_text("L;ab;CKS:99>cd"); add_field(FS_EXACT, 1'b1); ship_frame(99);
    ship_text("S;x;CKS:99999>");
    ship_text("S;x;CKS:256>");
    frame_buf.delete(); add_text("P;q"); add_field(FS_PADDED, 1'b1); ship_frame(99);
    frame_buf.delete(); add_text("N;pq"); add_field(FS_EXACT, 1'b0); ship_frame(99);
    ship_text("NOSEMI");
    frame_buf.delete(); frame_buf.push_back(8'hFF); ship_frame(1);
    frame_buf.delete(); frame_buf.push_back(8'h00); ship_frame(1);
    frame_buf.delete(); add_text("Z;"); frame_buf.push_back(8'h00);
    add_field(FS_EXACT, 1'b1); ship_frame(99);
    ship_text("Q;r;CK");
    frame_buf.delete(); add_text(";a;b"); add_field(FS_EXACT, 1'b1); ship_frame(99);
    ship_text("G;x;CKS:>12");
    wait_drained();

    // receiver holds off while frames keep coming
    repeat (10) begin
      build_body($urandom_range(1, 8));
      add_field(FS_EXACT, 1'b1);
      ship_frame(frame_buf.size());
    end
    hold_req = 1'b1;
    wait_drained();

    rand_bytes = 0;
    while (rand_bytes < RANDOM_BYTES) random_frame();
    while (byte_q.size() > 150) @(negedge clk_i);
    idle_on = 1'b0;

    while (byte_q.size() != 0 || in_if.valid) @(negedge clk_i);
    for (int n = 0; n < 1000 && verdict_q.size() != 0; n++) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (verdict_q.size() != 0) begin
      $error("%0d expected results never arrived", verdict_q.size());
      fault_cnt++;
    end
    if (fault_cnt == 0) begin
      $display("** framed_message_checksum_checker_top: PASSED **");
    end else begin
      $display("** framed_message_checksum_checker_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/fmcc_pkg.sv
rtl/core/fmcc_in_if.sv
rtl/core/fmcc_out_if.sv
rtl/core/fmcc_frame_track.sv
rtl/core/fmcc_digit_parse.sv
rtl/core/fmcc_result.sv
rtl/core/framed_message_checksum_checker_top.sv
bench/framed_message_checksum_checker_top_tb.sv
